FILE: hw/rtl/dstt_pkg.sv
// Shared package for the delay slot timer table.
// Holds sizing constants, operation and result codes, and the control/status structs.
// No dependencies.
`default_nettype none

package dstt_pkg;

    localparam int SLOT_COUNT = 20;
    localparam int OWNER_BITS = 8;

    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_FIELD_W  = 5;
    localparam int OWNER_FIELD_W = 8;
    localparam int TICKS_W       = 16;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REQUEST  = 1'b1;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [OWNER_BITS-1:0] owner_t;

    typedef struct packed {
        logic load;
        logic step;
        logic claim;
        logic reply_full;
        logic tick_eval;
        logic flush;
    } dstt_cmd_t;

    typedef struct packed {
        logic cur_free;
        logic at_end;
    } dstt_status_t;

    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input idx_t idx);
        logic [IDX_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, idx};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

    function automatic owner_t owner_trim(input logic [OWNER_FIELD_W-1:0] id);
        logic [OWNER_BITS+OWNER_FIELD_W-1:0] wide;
        wide = {{OWNER_BITS{1'b0}}, id};
        return wide[OWNER_BITS-1:0];
    endfunction

    function automatic logic [OWNER_FIELD_W-1:0] owner_widen(input owner_t own);
        logic [OWNER_BITS+OWNER_FIELD_W-1:0] wide;
        wide = {{OWNER_FIELD_W{1'b0}}, own};
        return wide[OWNER_FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/delay_slot_timer_table_unit.sv
// Top level of the delay slot timer table.
// Depends on dstt_pkg, dstt_ctrl and dstt_datapath.
//
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high and
//   busy low. operation selects a tick or a slot request; owner_id and
//   delay_ticks go with it.
//   Result channel: each result sits on kind, accepted, slot_index, notify_owner
//   and last for exactly one cycle, flagged by result_strobe. The receiver
//   cannot stall it. last marks the final result of a command.
//   Request: walks the busy flags from slot 0 and stops at the first free one,
//   or at the last slot when full. The reply is registered and appears in the
//   cycle after the decision.
//   Tick: walks all SLOT_COUNT slots, one per cycle through the shared
//   decrement/compare unit, then a flush state emits the held final expiry.
//   Each expiry is held back until the next one (or the end of the walk) is
//   known, so it can carry the right last flag.
//   A tick with nothing expiring produces no result.
//   Reset: all slots free, controller idle, no result pending.
`default_nettype none

module delay_slot_timer_table_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 operation,
    input  wire logic [dstt_pkg::OWNER_FIELD_W-1:0]   owner_id,
    input  wire logic [dstt_pkg::TICKS_W-1:0]         delay_ticks,
    output logic                                      result_strobe,
    output logic                                      kind,
    output logic                                      accepted,
    output logic [dstt_pkg::SLOT_FIELD_W-1:0]         slot_index,
    output logic [dstt_pkg::OWNER_FIELD_W-1:0]        notify_owner,
    output logic                                      last
);
    import dstt_pkg::*;

    dstt_cmd_t    cmd;
    dstt_status_t status;

    dstt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    dstt_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .owner_id      (owner_id),
        .delay_ticks   (delay_ticks),
        .status        (status),
        .result_strobe (result_strobe),
        .kind          (kind),
        .accepted      (accepted),
        .slot_index    (slot_index),
        .notify_owner  (notify_owner),
        .last          (last)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/dstt_ctrl.sv
// Controller for the delay slot timer table: sequences the slot walk.
// Depends on dstt_pkg for the command and status structs.
`default_nettype none

module dstt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  operation,
    input  wire dstt_pkg::dstt_status_t status,
    output dstt_pkg::dstt_cmd_t        cmd,
    output logic                       busy
);
    import dstt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REQ   = 2'd1;
    localparam logic [1:0] ST_TICK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (operation == OP_REQUEST) ? ST_REQ : ST_TICK;
                end
            end
            ST_REQ:
            begin
                if (status.cur_free)
                begin
                    cmd.claim  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.at_end)
                begin
                    cmd.reply_full = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_TICK:
            begin
                cmd.tick_eval = 1'b1;
                if (status.at_end)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/dstt_datapath.sv
// Datapath for the delay slot timer table: slot store, walk index, pending expiry
// and result registers. Depends on dstt_pkg; driven by dstt_ctrl.
`default_nettype none

module dstt_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire dstt_pkg::dstt_cmd_t                  cmd,
    input  wire logic [dstt_pkg::OWNER_FIELD_W-1:0]   owner_id,
    input  wire logic [dstt_pkg::TICKS_W-1:0]         delay_ticks,
    output dstt_pkg::dstt_status_t                    status,
    output logic                                      result_strobe,
    output logic                                      kind,
    output logic                                      accepted,
    output logic [dstt_pkg::SLOT_FIELD_W-1:0]         slot_index,
    output logic [dstt_pkg::OWNER_FIELD_W-1:0]        notify_owner,
    output logic                                      last
);
    import dstt_pkg::*;

    logic [SLOT_COUNT-1:0] busy_reg, busy_next;
    owner_t                owner_reg [SLOT_COUNT];
    logic [TICKS_W-1:0]    remain_reg [SLOT_COUNT];

    idx_t               idx_reg, idx_next;
    owner_t             req_owner_reg, req_owner_next;
    logic [TICKS_W-1:0] req_ticks_reg, req_ticks_next;

    logic   pend_valid_reg, pend_valid_next;
    idx_t   pend_idx_reg, pend_idx_next;
    owner_t pend_owner_reg, pend_owner_next;

    logic                     strobe_reg, strobe_next;
    logic                     kind_reg, kind_next;
    logic                     acc_reg, acc_next;
    logic [SLOT_FIELD_W-1:0]  slot_reg, slot_next;
    logic [OWNER_FIELD_W-1:0] nown_reg, nown_next;
    logic                     last_reg, last_next;

    owner_t             cur_owner;
    logic [TICKS_W-1:0] cur_remain;
    logic               cur_busy;

    assign cur_owner  = owner_reg[idx_reg];
    assign cur_remain = remain_reg[idx_reg];
    assign cur_busy   = busy_reg[idx_reg];

    assign status.cur_free = !cur_busy;
    assign status.at_end   = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    always_comb
    begin
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        req_owner_next  = req_owner_reg;
        req_ticks_next  = req_ticks_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_owner_next = pend_owner_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        acc_next        = acc_reg;
        slot_next       = slot_reg;
        nown_next       = nown_reg;
        last_next       = last_reg;

        if (cmd.load)
        begin
            idx_next        = '0;
            req_owner_next  = owner_trim(owner_id);
            req_ticks_next  = delay_ticks;
            pend_valid_next = 1'b0;
        end

        if (cmd.step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.claim)
        begin
            busy_next[idx_reg] = 1'b1;
            strobe_next = 1'b1;
            kind_next   = KIND_REPLY;
            acc_next    = 1'b1;
            slot_next   = slot_field(idx_reg);
            nown_next   = owner_widen(req_owner_reg);
            last_next   = 1'b1;
        end

        if (cmd.reply_full)
        begin
            strobe_next = 1'b1;
            kind_next   = KIND_REPLY;
            acc_next    = 1'b0;
            slot_next   = '0;
            nown_next   = owner_widen(req_owner_reg);
            last_next   = 1'b1;
        end

        if (cmd.tick_eval && cur_busy && (cur_remain == '0))
        begin
            busy_next[idx_reg] = 1'b0;
            if (pend_valid_reg)
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_EXPIRY;
                acc_next    = 1'b0;
                slot_next   = slot_field(pend_idx_reg);
                nown_next   = owner_widen(pend_owner_reg);
                last_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = idx_reg;
            pend_owner_next = cur_owner;
        end

        if (cmd.flush && pend_valid_reg)
        begin
            strobe_next     = 1'b1;
            kind_next       = KIND_EXPIRY;
            acc_next        = 1'b0;
            slot_next       = slot_field(pend_idx_reg);
            nown_next       = owner_widen(pend_owner_reg);
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        req_owner_reg  <= req_owner_next;
        req_ticks_reg  <= req_ticks_next;
        pend_idx_reg   <= pend_idx_next;
        pend_owner_reg <= pend_owner_next;
        kind_reg       <= kind_next;
        acc_reg        <= acc_next;
        slot_reg       <= slot_next;
        nown_reg       <= nown_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
        begin
            owner_reg[idx_reg]  <= req_owner_reg;
            remain_reg[idx_reg] <= req_ticks_reg;
        end
        else if (cmd.tick_eval && cur_busy && (cur_remain != '0))
        begin
            remain_reg[idx_reg] <= cur_remain - TICKS_W'(1);
        end
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign accepted      = acc_reg;
    assign slot_index    = slot_reg;
    assign notify_owner  = nown_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dstt_checker.sv
// Port-level checker for the delay slot timer table, bound to the top level.
// Depends on dstt_pkg for result codes.
`default_nettype none

module dstt_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic                                 result_strobe,
    input wire logic                                 kind,
    input wire logic                                 accepted,
    input wire logic [dstt_pkg::SLOT_FIELD_W-1:0]    slot_index,
    input wire logic                                 last
);
    import dstt_pkg::*;

    a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (kind == KIND_REPLY)) |-> last)
        else $error("request reply without last flag");

    a_full_reply_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (kind == KIND_REPLY) && !accepted) |-> (slot_index == '0))
        else $error("rejected reply names a slot");

    a_expiry_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (kind == KIND_EXPIRY)) |-> !accepted)
        else $error("expiry notice flagged accepted");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !result_strobe)
        else $error("result strobed in first busy cycle");

endmodule

bind delay_slot_timer_table_unit dstt_checker u_dstt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .kind          (kind),
    .accepted      (accepted),
    .slot_index    (slot_index),
    .last          (last)
);

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the delay slot timer table: directed and random tick and request
// transactions, with a scoreboard class that predicts every reply and expiry.
// Depends on dstt_pkg and delay_slot_timer_table_unit.

module tb_top;
    import dstt_pkg::*;

    localparam int TOTAL_ITEMS    = 160;
    localparam int STALL_LIMIT    = 1000;

    typedef struct packed {
        logic                     kind;
        logic                     accepted;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [OWNER_FIELD_W-1:0] owner;
        logic                     last;
    } timer_result_t;

    class timer_table_scoreboard;
        logic               taken [SLOT_COUNT];
        owner_t             owner_of [SLOT_COUNT];
        logic [TICKS_W-1:0] ticks_left [SLOT_COUNT];
        timer_result_t      pending [$];
        int                 errors;

        function new();
            foreach (taken[i])
                taken[i] = 1'b0;
            errors = 0;
        endfunction

        function void note_transaction(logic op, logic [OWNER_FIELD_W-1:0] who,
                                       logic [TICKS_W-1:0] ticks);
            timer_result_t res;
            logic          held;
            owner_t        own;
            own  = owner_t'(who);
            held = 1'b0;
            res  = '0;
            if (op == OP_REQUEST)
            begin
                res.kind  = KIND_REPLY;
                res.owner = OWNER_FIELD_W'(own);
                res.last  = 1'b1;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!taken[i] && !res.accepted)
                    begin
                        taken[i]      = 1'b1;
                        owner_of[i]   = own;
                        ticks_left[i] = ticks;
                        res.accepted  = 1'b1;
                        res.slot      = SLOT_FIELD_W'(i);
                    end
                end
                pending.push_back(res);
            end
            else
            begin
                // hold each expiry until the next one shows whether it is the final one
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (taken[i])
                    begin
                        if (ticks_left[i] != '0)
                            ticks_left[i] = ticks_left[i] - TICKS_W'(1);
                        else
                        begin
                            if (held)
                                pending.push_back(res);
                            res.kind     = KIND_EXPIRY;
                            res.accepted = 1'b0;
                            res.slot     = SLOT_FIELD_W'(i);
                            res.owner    = OWNER_FIELD_W'(owner_of[i]);
                            res.last     = 1'b0;
                            held         = 1'b1;
                            taken[i]     = 1'b0;
                        end
                    end
                end
                if (held)
                begin
                    res.last = 1'b1;
                    pending.push_back(res);
                end
            end
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d owner %0d",
                       got.kind, got.slot, got.owner);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.accepted !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.owner !== want.owner)
            begin
                $error("notify_owner: expected %0d, got %0d", want.owner, got.owner);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [OWNER_FIELD_W-1:0] owner_id;
    logic [TICKS_W-1:0]       delay_ticks;
    logic                     result_strobe;
    logic                     kind;
    logic                     accepted;
    logic [SLOT_FIELD_W-1:0]  slot_index;
    logic [OWNER_FIELD_W-1:0] notify_owner;
    logic                     last;

    timer_table_scoreboard sb;
    bit                    gaps_on;
    int                    items_sent;

    delay_slot_timer_table_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .owner_id      (owner_id),
        .delay_ticks   (delay_ticks),
        .result_strobe (result_strobe),
        .kind          (kind),
        .accepted      (accepted),
        .slot_index    (slot_index),
        .notify_owner  (notify_owner),
        .last          (last)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [TICKS_W-1:0] random_delay();
        if ($urandom_range(0, 15) == 0)
            return TICKS_W'($urandom);
        return TICKS_W'($urandom_range(0, 6));
    endfunction

    task automatic send_item(input logic op, input logic [OWNER_FIELD_W-1:0] who,
                             input logic [TICKS_W-1:0] ticks);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= op;
        owner_id    <= who;
        delay_ticks <= ticks;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_transaction(op, who, ticks);
        items_sent++;
    endtask

    task automatic request_burst(input int count);
        repeat (count)
            send_item(OP_REQUEST, OWNER_FIELD_W'($urandom), random_delay());
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_strobe === 1'b1)
            sb.check_result({kind, accepted, slot_index, notify_owner, last});
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) ||
                result_strobe === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        sb          = new();
        gaps_on     = 1'b1;
        items_sent  = 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        operation   <= OP_TICK;
        owner_id    <= '0;
        delay_ticks <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, zero delay, zero and full owner, longest delay, double expiry
        send_item(OP_TICK,    8'h00, 16'h0000);
        send_item(OP_REQUEST, 8'h00, 16'h0000);
        send_item(OP_REQUEST, 8'hFF, 16'hFFFF);
        send_item(OP_REQUEST, 8'h5A, 16'h0001);
        send_item(OP_REQUEST, 8'hA5, 16'h0002);
        send_item(OP_TICK,    8'hFF, 16'hFFFF);
        send_item(OP_REQUEST, 8'h3C, 16'h0000);
        send_item(OP_TICK,    8'h00, 16'h0000);
        send_item(OP_TICK,    8'h00, 16'h0000);

        // fill past capacity, tick once, then drain every result
        request_burst(SLOT_COUNT + 2);
        send_item(OP_TICK, OWNER_FIELD_W'($urandom), TICKS_W'($urandom));
        wait_for_results();

        while (items_sent < TOTAL_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 3))
                0: request_burst($urandom_range(1, SLOT_COUNT + 2));
                1: repeat ($urandom_range(1, 8))
                       send_item(OP_TICK, OWNER_FIELD_W'($urandom), TICKS_W'($urandom));
                2: repeat ($urandom_range(4, 12))
                       send_item(1'($urandom), OWNER_FIELD_W'($urandom), random_delay());
                default: wait_for_results();
            endcase
        end

        wait_for_results();
        repeat (SLOT_COUNT + 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dstt_pkg.sv
hw/rtl/dstt_ctrl.sv
hw/rtl/dstt_datapath.sv
hw/rtl/delay_slot_timer_table_unit.sv
hw/rtl/dstt_checker.sv
test/tb_top.sv
